/* src/kcl_pkg.sv */
package kcl_pkg;

    localparam int unsigned KEY_COUNT       = 12;
    localparam int unsigned DIGIT_W         = 4;
    localparam int unsigned LED_W           = 3;
    localparam int unsigned CODE_SLOTS      = 3;
    localparam int unsigned CODE_LENGTH_DEF = 3;
    localparam int unsigned QUEUE_DEPTH_DEF = 2;
    localparam int unsigned IN_TDATA_W      = 16;
    localparam int unsigned OUT_TDATA_W     = 16;
    localparam int unsigned CFG_INDEX_W     = 2;

    localparam logic [DIGIT_W-1:0] NO_KEY = 4'd15;
    localparam logic [LED_W-1:0]   LED_WHITE = 3'd0;
    localparam logic [LED_W-1:0]   LED_OFF   = 3'd7;

    localparam logic [DIGIT_W-1:0] CODE_RESET [CODE_SLOTS] = '{4'd1, 4'd2, 4'd3};

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CODE_FIRST  = 2'd0,
        REG_CODE_SECOND = 2'd1,
        REG_CODE_THIRD  = 2'd2,
        REG_UNUSED      = 2'd3
    } kcl_reg_index_t;

    // Classified scan passed from front to back
    typedef struct packed {
        logic               pressed;
        logic [DIGIT_W-1:0] key;
    } kcl_item_t;

    // Result word, last field in the lowest bits
    typedef struct packed {
        logic               code_matched;
        logic               code_checked;
        logic               is_locked;
        logic               led_blue_n;
        logic               led_green_n;
        logic               led_red_n;
        logic [DIGIT_W-1:0] key_code;
        logic               new_press;
    } kcl_result_t;

    localparam int unsigned RESULT_W = $bits(kcl_result_t);

    // Scan position (row-major) to key code: 1..9, star, 0, hash
    function automatic logic [DIGIT_W-1:0] key_of_pos(input logic [3:0] pos);
        logic [DIGIT_W-1:0] k;
        unique case (pos)
            4'd0:  k = 4'd1;
            4'd1:  k = 4'd2;
            4'd2:  k = 4'd3;
            4'd3:  k = 4'd4;
            4'd4:  k = 4'd5;
            4'd5:  k = 4'd6;
            4'd6:  k = 4'd7;
            4'd7:  k = 4'd8;
            4'd8:  k = 4'd9;
            4'd9:  k = 4'd10;
            4'd10: k = 4'd0;
            4'd11: k = 4'd11;
            default: k = 4'd0;
        endcase
        return k;
    endfunction

    // Active-low drive per key code: bit0 red, bit1 green, bit2 blue
    function automatic logic [LED_W-1:0] colour_of_key(input logic [DIGIT_W-1:0] key);
        logic [LED_W-1:0] c;
        unique case (key)
            4'd0:  c = 3'd2;
            4'd1:  c = 3'd6;
            4'd2:  c = 3'd5;
            4'd3:  c = 3'd3;
            4'd4:  c = 3'd4;
            4'd5:  c = 3'd2;
            4'd6:  c = 3'd1;
            4'd7:  c = 3'd6;
            4'd8:  c = 3'd5;
            4'd9:  c = 3'd3;
            4'd10: c = 3'd4;
            4'd11: c = 3'd1;
            default: c = 3'd2;
        endcase
        return c;
    endfunction

endpackage

/* src/kcl_front.sv */
module kcl_front (
    input  logic [kcl_pkg::KEY_COUNT-1:0] pressed_keys,
    output kcl_pkg::kcl_item_t            item
);
    import kcl_pkg::*;

    logic             found;
    logic [3:0]       pos;

    // Lowest set bit wins
    always_comb begin
        found = 1'b0;
        pos   = '0;
        for (int i = KEY_COUNT - 1; i >= 0; i--) begin
            if (pressed_keys[i]) begin
                found = 1'b1;
                pos   = 4'(i);
            end
        end
        item.pressed = found;
        item.key     = found ? key_of_pos(pos) : '0;
    end

endmodule

/* src/kcl_queue.sv */
module kcl_queue #(
    parameter int unsigned DEPTH = kcl_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  kcl_pkg::kcl_item_t push_item,
    output logic               full,
    input  logic               pop,
    output logic               not_empty,
    output kcl_pkg::kcl_item_t pop_item
);
    import kcl_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    kcl_item_t         slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign pop_item  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* src/kcl_back.sv */
module kcl_back #(
    parameter int unsigned CODE_LENGTH = kcl_pkg::CODE_LENGTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [kcl_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [kcl_pkg::DIGIT_W-1:0]      cfg_data,
    input  logic                             item_valid,
    input  kcl_pkg::kcl_item_t               item,
    output logic                             item_take,
    output logic                             res_valid,
    output kcl_pkg::kcl_result_t             res,
    input  logic                             res_ready
);
    import kcl_pkg::*;

    localparam logic [1:0] LAST_SLOT = 2'(CODE_LENGTH - 1);

    logic [DIGIT_W-1:0] code_reg  [CODE_SLOTS];
    logic [DIGIT_W-1:0] digit_reg [CODE_SLOTS];
    logic [DIGIT_W-1:0] digit_next [CODE_SLOTS];
    logic [DIGIT_W-1:0] prev_key_reg, prev_key_next;
    logic [1:0]         count_reg, count_next;
    logic               locked_reg, locked_next;
    logic [LED_W-1:0]   led_reg, led_next;
    logic               out_valid_reg, out_valid_next;
    kcl_result_t        out_reg, out_next;
    logic               ok;
    logic [DIGIT_W-1:0] entry_digit;

    // Advance when the output word is free or being taken
    assign item_take = item_valid && (!out_valid_reg || res_ready);
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    always_comb begin
        prev_key_next  = prev_key_reg;
        count_next     = count_reg;
        locked_next    = locked_reg;
        led_next       = led_reg;
        digit_next     = digit_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        ok             = 1'b1;
        entry_digit    = '0;

        if (res_ready) begin
            out_valid_next = 1'b0;
        end

        if (item_take) begin
            out_next.new_press    = 1'b0;
            out_next.key_code     = '0;
            out_next.code_checked = 1'b0;
            out_next.code_matched = 1'b0;

            if (item.pressed) begin
                if (item.key != prev_key_reg) begin
                    prev_key_next      = item.key;
                    out_next.new_press = 1'b1;
                    out_next.key_code  = item.key;
                    if (locked_reg) begin
                        if (count_reg == LAST_SLOT) begin
                            // Entry complete: compare with the new digit in place
                            for (int i = 0; i < CODE_SLOTS; i++) begin
                                entry_digit = (2'(i) == count_reg) ? item.key : digit_reg[i];
                                if (i < CODE_LENGTH && entry_digit != code_reg[i]) begin
                                    ok = 1'b0;
                                end
                            end
                            out_next.code_checked = 1'b1;
                            if (ok) begin
                                out_next.code_matched = 1'b1;
                                locked_next           = 1'b0;
                                led_next              = LED_WHITE;
                            end
                            count_next = '0;
                            for (int i = 0; i < CODE_SLOTS; i++) begin
                                digit_next[i] = '0;
                            end
                        end else begin
                            digit_next[count_reg] = item.key;
                            count_next            = count_reg + 1'b1;
                        end
                    end else begin
                        led_next = colour_of_key(item.key);
                    end
                end
            end else if (prev_key_reg != NO_KEY) begin
                prev_key_next = NO_KEY;
                led_next      = locked_reg ? LED_WHITE : LED_OFF;
            end

            out_next.led_red_n   = led_next[0];
            out_next.led_green_n = led_next[1];
            out_next.led_blue_n  = led_next[2];
            out_next.is_locked   = locked_next;
            out_valid_next       = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_key_reg  <= NO_KEY;
            count_reg     <= '0;
            locked_reg    <= 1'b1;
            led_reg       <= LED_WHITE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < CODE_SLOTS; i++) begin
                digit_reg[i] <= '0;
                code_reg[i]  <= CODE_RESET[i];
            end
        end else begin
            prev_key_reg  <= prev_key_next;
            count_reg     <= count_next;
            locked_reg    <= locked_next;
            led_reg       <= led_next;
            out_valid_reg <= out_valid_next;
            digit_reg     <= digit_next;
            if (cfg_we) begin
                unique case (kcl_reg_index_t'(cfg_index))
                    REG_CODE_FIRST:  code_reg[0] <= cfg_data;
                    REG_CODE_SECOND: code_reg[1] <= cfg_data;
                    REG_CODE_THIRD:  code_reg[2] <= cfg_data;
                    REG_UNUSED:      ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

endmodule

/* src/keypad_code_lock_core.sv */
// Channel  | Direction | Ports                                     | Word
// ---------+-----------+-------------------------------------------+--------------------------
// s_       | in        | s_tvalid s_tready s_tdata[15:0]           | one keypad scan
// m_       | out       | m_tvalid m_tready m_tdata[15:0]           | one result per scan
// cfg_     | in        | cfg_valid cfg_ready cfg_index cfg_data    | unlock code digit write
//
// One word per cycle sustained while m_tready stays high. A scan's result is offered on
// m_ at the earliest once it has passed the queue (written on the accepting edge) and then
// the output register (written by the state update). The queue holds QUEUE_DEPTH
// scans so input and output stall independently. Reset (aresetn, synchronous) relocks,
// clears the entry, restores the default code 1-2-3 and empties the queue.
// cfg_ready is always high.
module keypad_code_lock_core #(
    parameter int unsigned CODE_LENGTH = kcl_pkg::CODE_LENGTH_DEF,
    parameter int unsigned QUEUE_DEPTH = kcl_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [kcl_pkg::IN_TDATA_W-1:0]   s_tdata,   // [11:0] pressed_keys
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] new_press, [4:1] key_code, [5] led_red_n, [6] led_green_n,
    // [7] led_blue_n, [8] is_locked, [9] code_checked, [10] code_matched
    output logic [kcl_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [kcl_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [kcl_pkg::DIGIT_W-1:0]      cfg_data
);
    import kcl_pkg::*;

    kcl_item_t   front_item;
    kcl_item_t   queue_item;
    logic        queue_full;
    logic        queue_valid;
    logic        back_take;
    logic        in_take;
    kcl_result_t result;

    assign s_tready  = !queue_full;
    assign in_take   = s_tvalid && !queue_full;
    assign cfg_ready = 1'b1;
    assign m_tdata   = {(OUT_TDATA_W - RESULT_W)'(0), result};

    kcl_front u_front (
        .pressed_keys (s_tdata[KEY_COUNT-1:0]),
        .item         (front_item)
    );

    kcl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (in_take),
        .push_item (front_item),
        .full      (queue_full),
        .pop       (back_take),
        .not_empty (queue_valid),
        .pop_item  (queue_item)
    );

    kcl_back #(
        .CODE_LENGTH (CODE_LENGTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_valid (queue_valid),
        .item       (queue_item),
        .item_take  (back_take),
        .res_valid  (m_tvalid),
        .res        (result),
        .res_ready  (m_tready)
    );

endmodule
